// ----- design/asgr_pkg.sv -----
package asgr_pkg;

   typedef enum logic [1:0] {
      PH_TEXT = 2'd0,
      PH_ESC  = 2'd1,
      PH_CSI  = 2'd2
   } phase_type;

   localparam logic [7:0]  CH_ESC      = 8'h1B;
   localparam logic [7:0]  CH_BRACKET  = 8'h5B;
   localparam logic [7:0]  CH_FINAL_M  = 8'h6D;
   localparam logic [7:0]  CH_DIGIT_0  = 8'h30;
   localparam logic [7:0]  CH_DIGIT_9  = 8'h39;
   localparam logic [7:0]  CH_UPPER_A  = 8'h41;
   localparam logic [7:0]  CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0]  CH_LOWER_A  = 8'h61;
   localparam logic [7:0]  CH_LOWER_Z  = 8'h7A;

   localparam logic [7:0]  SGR_RESET     = 8'd0;
   localparam logic [7:0]  SGR_BOLD      = 8'd1;
   localparam logic [7:0]  SGR_UNDERLINE = 8'd4;
   localparam logic [7:0]  SGR_REVERSE   = 8'd7;
   localparam logic [7:0]  FG_BASE       = 8'd30;
   localparam logic [7:0]  BG_BASE       = 8'd40;
   localparam logic [7:0]  COLOUR_SPAN   = 8'd7;
   localparam logic [7:0]  PARAM_MAX     = 8'd255;

   localparam logic [15:0] ATTR_BOLD       = 16'h0008;
   localparam logic [15:0] ATTR_REVERSE    = 16'h4000;
   localparam logic [15:0] ATTR_UNDERSCORE = 16'h8000;

   localparam logic [15:0] BASE_ATTR_RESET    = 16'h0007;
   localparam logic        CONSOLE_MODE_RESET = 1'b1;

   localparam logic CSR_CONSOLE_MODE = 1'b0;
   localparam logic CSR_BASE_ATTR    = 1'b1;

   localparam int RESULT_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic [15:0] text_attribute;
      logic        out_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // colour index bit 0 is red, bit 1 green, bit 2 blue; attribute order is r/g/b high to low
   function automatic logic [2:0] colour_bits(input logic [2:0] idx);
      colour_bits = {idx[0], idx[1], idx[2]};
   endfunction

   function automatic logic [15:0] apply_param(input logic [7:0] code,
                                                input logic [15:0] attr,
                                                input logic [15:0] base);
      logic [7:0]  fg_idx;
      logic [7:0]  bg_idx;
      logic [15:0] a;
      fg_idx = code - FG_BASE;
      bg_idx = code - BG_BASE;
      a = attr;
      priority if (code == SGR_RESET) begin
         a = base;
      end else if (code == SGR_BOLD) begin
         a = attr | ATTR_BOLD;
      end else if (code == SGR_UNDERLINE) begin
         a = attr | ATTR_UNDERSCORE;
      end else if (code == SGR_REVERSE) begin
         a = attr | ATTR_REVERSE;
      end else if (code >= FG_BASE && code <= FG_BASE + COLOUR_SPAN) begin
         a = {attr[15:3], colour_bits(fg_idx[2:0])};
      end else if (code >= BG_BASE && code <= BG_BASE + COLOUR_SPAN) begin
         a = {attr[15:7], colour_bits(bg_idx[2:0]), attr[3:0]};
      end else begin
         a = attr;
      end
      apply_param = a;
   endfunction

endpackage

// ----- design/asgr_parser.sv -----
module asgr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 console_mode,
   input  logic [15:0]          base_attribute,
   output asgr_pkg::push_type   push
);
   import asgr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  param_ff, param_in;
   logic [15:0] work_ff, work_in;
   logic [15:0] cur_ff, cur_in;
   logic [11:0] param_sum;
   logic        is_digit;
   logic        is_letter;
   logic [15:0] applied;

   assign is_digit  = (in_byte >= CH_DIGIT_0) && (in_byte <= CH_DIGIT_9);
   assign is_letter = ((in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z)) ||
                      ((in_byte >= CH_LOWER_A) && (in_byte <= CH_LOWER_Z));
   assign param_sum = {4'b0, param_ff} * 12'd10 + {8'b0, in_byte[3:0]};
   assign applied   = apply_param(param_ff, work_ff, base_attribute);

   always_comb begin
      phase_in = phase_ff;
      param_in = param_ff;
      work_in  = work_ff;
      cur_in   = cur_ff;
      push     = '0;
      if (step) begin
         unique case (phase_ff)
            PH_ESC: begin
               if (in_byte == CH_BRACKET) begin
                  phase_in = PH_CSI;
                  param_in = '0;
                  work_in  = cur_ff;
               end else if (in_byte == CH_ESC) begin
                  // release the held escape, keep the new one
                  push.count  = 2'd1;
                  push.first  = '{text_byte: CH_ESC, text_attribute: cur_ff, out_last: 1'b1};
               end else begin
                  phase_in    = PH_TEXT;
                  push.count  = 2'd2;
                  push.first  = '{text_byte: CH_ESC, text_attribute: cur_ff, out_last: 1'b0};
                  push.second = '{text_byte: in_byte, text_attribute: cur_ff, out_last: 1'b1};
               end
            end
            PH_CSI: begin
               if (is_digit) begin
                  param_in = (param_sum > {4'b0, PARAM_MAX}) ? PARAM_MAX : param_sum[7:0];
               end else if (is_letter) begin
                  work_in  = applied;
                  param_in = '0;
                  phase_in = PH_TEXT;
                  if (in_byte == CH_FINAL_M && console_mode) begin
                     cur_in = applied;
                  end
               end else begin
                  work_in  = applied;
                  param_in = '0;
               end
            end
            default: begin
               if (in_byte == CH_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  phase_in   = PH_TEXT;
                  push.count = 2'd1;
                  push.first = '{text_byte: in_byte, text_attribute: cur_ff, out_last: 1'b1};
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         param_ff <= '0;
         work_ff  <= BASE_ATTR_RESET;
         cur_ff   <= BASE_ATTR_RESET;
      end else begin
         phase_ff <= phase_in;
         param_ff <= param_in;
         work_ff  <= work_in;
         cur_ff   <= cur_in;
      end
   end

endmodule

// ----- design/asgr_result_fifo.sv -----
module asgr_result_fifo #(
   parameter int DEPTH = asgr_pkg::RESULT_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  asgr_pkg::push_type    push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_pop,
   output asgr_pkg::result_type  out_word
);
   import asgr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

   result_type    mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      wrap_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // two free slots always kept for the worst-case word
   assign room      = (count_ff <= ROOM_LIMIT);
   assign out_valid = (count_ff != '0);
   assign out_word  = mem[rd_ptr_ff];
   assign wr_next   = wrap_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = wrap_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = out_pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.count) - CW'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/ansi_sgr_escape_filter.sv -----
// Terminal byte-stream filter: strips ESC [ ... letter control sequences and
// tags every text byte with the current attribute word (SGR codes 0/1/4/7,
// 30-37, 40-47 of an 'm' sequence applied when console mode is set).
// Request channel: req_valid / req_stall with req_in_byte, one byte per word.
// Response channel: rsp_valid / rsp_stall with rsp_text_byte,
// rsp_text_attribute and rsp_out_last; a request byte gives zero, one or two
// response words, the last one flagged by rsp_out_last.
// CSR channel: csr_valid / csr_ready, csr_index 0 = console mode,
// 1 = base attribute; csr_ready is always high. Write only while idle.
// A byte is registered on entry, then parsed; its words are visible on the
// response port in the cycle after parsing. Throughput: one byte per cycle
// when not stalled; an ESC followed by a non-'[' byte gives two words, so
// the response port, not the parser, limits the sustained rate.
// A byte is parsed only while the result queue has two free slots; with the
// response side stalled the queue fills and req_stall rises.
// Reset clears the queue, returns the parser to plain text and restores
// console mode 1 and base attribute 7.
module ansi_sgr_escape_filter #(
   parameter int RESULT_DEPTH = asgr_pkg::RESULT_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_text_byte,
   output logic [15:0] rsp_text_attribute,
   output logic        rsp_out_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import asgr_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        console_mode_ff, console_mode_in;
   logic [15:0] base_attr_ff, base_attr_in;
   logic        room;
   logic        step;
   logic        accept;
   push_type    push;
   result_type  out_word;

   assign step      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      console_mode_in = console_mode_ff;
      base_attr_in    = base_attr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CONSOLE_MODE: console_mode_in = csr_data[0];
            CSR_BASE_ATTR:    base_attr_in    = csr_data;
            default:          base_attr_in    = base_attr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (reset) begin
         in_valid_ff     <= 1'b0;
         console_mode_ff <= CONSOLE_MODE_RESET;
         base_attr_ff    <= BASE_ATTR_RESET;
      end else begin
         in_valid_ff     <= in_valid_in;
         console_mode_ff <= console_mode_in;
         base_attr_ff    <= base_attr_in;
      end
   end

   asgr_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .in_byte        (in_byte_ff),
      .console_mode   (console_mode_ff),
      .base_attribute (base_attr_ff),
      .push           (push)
   );

   asgr_result_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_pop   (rsp_valid && !rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_text_byte      = out_word.text_byte;
   assign rsp_text_attribute = out_word.text_attribute;
   assign rsp_out_last       = out_word.out_last;

endmodule

// ----- tb/sv/tb_ansi_sgr_escape_filter.sv -----
`timescale 1ns / 100ps

module tb_ansi_sgr_escape_filter;
   import asgr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_text_byte;
   logic [15:0] rsp_text_attribute;
   logic        rsp_out_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_CONSOLE_MODE;
   logic [15:0] csr_data = 16'h0000;

   ansi_sgr_escape_filter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_text_byte      (rsp_text_byte),
      .rsp_text_attribute (rsp_text_attribute),
      .rsp_out_last       (rsp_out_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   logic [7:0] bytes_to_send[$];
   result_type expected_words[$];
   int         fail_count = 0;
   int         snd_idle_pct = 0;
   int         rcv_stall_pct = 0;
   bit         sender_hold = 1'b0;

   // filter state as the block should hold it
   logic        cfg_console = CONSOLE_MODE_RESET;
   logic [15:0] cfg_base = BASE_ATTR_RESET;
   phase_type   parse_state = PH_TEXT;
   logic [7:0]  param_acc = 8'd0;
   logic [15:0] work_attr = BASE_ATTR_RESET;
   logic [15:0] cur_attr = BASE_ATTR_RESET;

   function automatic logic [15:0] sgr_update(input logic [7:0] code, input logic [15:0] attr);
      logic [7:0] idx;
      logic [2:0] rgb;
      if (code >= FG_BASE && code <= FG_BASE + 8'd7) begin
         idx = code - FG_BASE;
      end else begin
         idx = code - BG_BASE;
      end
      // colour index bit 0 is red, which sits at the top of the rgb field
      rgb[2] = idx[0];
      rgb[1] = idx[1];
      rgb[0] = idx[2];
      if (code == SGR_RESET) begin
         return cfg_base;
      end else if (code == SGR_BOLD) begin
         return attr | ATTR_BOLD;
      end else if (code == SGR_UNDERLINE) begin
         return attr | ATTR_UNDERSCORE;
      end else if (code == SGR_REVERSE) begin
         return attr | ATTR_REVERSE;
      end else if (code >= FG_BASE && code <= FG_BASE + 8'd7) begin
         return (attr & ~16'h0007) | {13'd0, rgb};
      end else if (code >= BG_BASE && code <= BG_BASE + 8'd7) begin
         return (attr & ~16'h0070) | {9'd0, rgb, 4'd0};
      end
      return attr;
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      bytes_to_send.insert(bytes_to_send.size(), b);
   endfunction

   function automatic void push_word(input logic [7:0] b, input logic last);
      result_type w;
      w.text_byte = b;
      w.text_attribute = cur_attr;
      w.out_last = last;
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void filter_byte(input logic [7:0] b);
      int acc;
      bit is_digit;
      bit is_letter;
      is_digit = (b >= CH_DIGIT_0 && b <= CH_DIGIT_9);
      is_letter = (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
      case (parse_state)
         PH_ESC: begin
            if (b == CH_BRACKET) begin
               parse_state = PH_CSI;
               param_acc = 8'd0;
               work_attr = cur_attr;
            end else if (b == CH_ESC) begin
               // release the held escape, keep the new one
               push_word(CH_ESC, 1'b1);
            end else begin
               parse_state = PH_TEXT;
               push_word(CH_ESC, 1'b0);
               push_word(b, 1'b1);
            end
         end
         PH_CSI: begin
            if (is_digit) begin
               acc = int'(param_acc) * 10 + int'(b) - int'(CH_DIGIT_0);
               param_acc = (acc > 255) ? PARAM_MAX : acc[7:0];
            end else begin
               work_attr = sgr_update(param_acc, work_attr);
               param_acc = 8'd0;
               if (is_letter) begin
                  if (b == CH_FINAL_M && cfg_console) begin
                     cur_attr = work_attr;
                  end
                  parse_state = PH_TEXT;
               end
            end
         end
         default: begin
            parse_state = PH_TEXT;
            if (b == CH_ESC) begin
               parse_state = PH_ESC;
            end else begin
               push_word(b, 1'b1);
            end
         end
      endcase
   endfunction

   // sender: hold a word until taken, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_byte(req_in_byte);
         end
         if (!(req_valid && req_stall)) begin
            if (bytes_to_send.size() != 0 && !sender_hold &&
                $urandom_range(99) >= snd_idle_pct) begin
               req_valid <= 1'b1;
               req_in_byte <= bytes_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
               req_in_byte <= 8'($urandom_range(255));
            end
         end
      end
   end

   // receiver: check each word taken against the oldest prediction
   always @(posedge clock) begin
      result_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word byte %h attr %h last %b", $time,
                        rsp_text_byte, rsp_text_attribute, rsp_out_last);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_text_byte !== w.text_byte) begin
                  $display("%0t: text_byte expected %h got %h", $time,
                           w.text_byte, rsp_text_byte);
                  fail_count++;
               end
               if (rsp_text_attribute !== w.text_attribute) begin
                  $display("%0t: text_attribute expected %h got %h", $time,
                           w.text_attribute, rsp_text_attribute);
                  fail_count++;
               end
               if (rsp_out_last !== w.out_last) begin
                  $display("%0t: out_last expected %b got %b", $time,
                           w.out_last, rsp_out_last);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   function automatic void queue_param();
      string s;
      int code;
      case ($urandom_range(9))
         0: code = 0;
         1: code = 1;
         2: code = 4;
         3: code = 7;
         4, 5: code = 30 + $urandom_range(7);
         6, 7: code = 40 + $urandom_range(7);
         8: code = $urandom_range(255);
         default: code = $urandom_range(999, 256);
      endcase
      // leave some parameters empty, pad others with a leading zero
      if ($urandom_range(9) == 0) begin
         return;
      end
      if ($urandom_range(9) == 0) begin
         append_byte(CH_DIGIT_0);
      end
      s = $sformatf("%0d", code);
      for (int i = 0; i < s.len(); i++) begin
         append_byte(s[i]);
      end
   endfunction

   function automatic void queue_sequence();
      int nparams;
      logic [7:0] sep;
      logic [7:0] fin;
      nparams = $urandom_range(4);
      append_byte(CH_ESC);
      append_byte(CH_BRACKET);
      for (int i = 0; i < nparams; i++) begin
         if (i != 0) begin
            sep = ";";
            if ($urandom_range(4) == 0) begin
               do begin
                  sep = 8'($urandom_range(255));
               end while ((sep >= CH_DIGIT_0 && sep <= CH_DIGIT_9) ||
                          (sep >= CH_UPPER_A && sep <= CH_UPPER_Z) ||
                          (sep >= CH_LOWER_A && sep <= CH_LOWER_Z));
            end
            append_byte(sep);
         end
         queue_param();
      end
      if ($urandom_range(4) != 0) begin
         fin = CH_FINAL_M;
      end else if ($urandom_range(1) == 0) begin
         fin = 8'($urandom_range(CH_UPPER_Z, CH_UPPER_A));
      end else begin
         fin = 8'($urandom_range(CH_LOWER_Z, CH_LOWER_A));
      end
      append_byte(fin);
   endfunction

   function automatic void queue_random(input int count);
      int target;
      int pick;
      target = bytes_to_send.size() + count;
      while (bytes_to_send.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            queue_sequence();
         end else if (pick < 85) begin
            repeat ($urandom_range(6, 1)) append_byte(8'($urandom_range(255)));
         end else begin
            // broken opener: escape then anything
            append_byte(CH_ESC);
            append_byte(8'($urandom_range(255)));
         end
      end
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (bytes_to_send.size() != 0 || req_valid || expected_words.size() != 0) begin
         @(negedge clock);
      end
      // bytes inside a sequence give no word but may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (idx == CSR_CONSOLE_MODE) begin
         cfg_console = data[0];
      end else begin
         cfg_base = data;
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int snd, input int rcv);
      @(negedge clock);
      snd_idle_pct = snd;
      rcv_stall_pct = rcv;
   endtask

   task automatic console_word(input logic mode);
      logic [15:0] data;
      data = 16'($urandom_range(16'hFFFF));
      data[0] = mode;
      write_csr(CSR_CONSOLE_MODE, data);
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = '{8'h00, 8'hFF,
                   CH_ESC, CH_BRACKET, "1", ";", "4", ";", "7", CH_FINAL_M,
                   CH_ESC, CH_BRACKET, "9", "9", "9", ";", "3", "5", ";", "4", "2", "H",
                   CH_ESC, "A",
                   CH_ESC, CH_ESC, CH_BRACKET, CH_FINAL_M};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) append_byte(directed[i]);
      wait_drained();

      console_word(1'b1);
      write_csr(CSR_BASE_ATTR, 16'hFFFF);
      set_idling(0, 0);
      queue_random(260);
      wait_drained();

      write_csr(CSR_BASE_ATTR, 16'($urandom_range(16'hFFFF)));
      set_idling(60, 0);
      queue_random(260);
      // stop feeding until the output side has caught up
      while (bytes_to_send.size() > 130) @(negedge clock);
      sender_hold = 1'b1;
      while (expected_words.size() != 0 || req_valid) @(negedge clock);
      sender_hold = 1'b0;
      wait_drained();

      console_word(1'b0);
      write_csr(CSR_BASE_ATTR, 16'h0000);
      set_idling(0, 60);
      queue_random(260);
      wait_drained();

      console_word(1'b1);
      write_csr(CSR_BASE_ATTR, 16'($urandom_range(16'hFFFF)));
      set_idling(16, 16);
      queue_random(260);
      wait_drained();

      write_csr(CSR_BASE_ATTR, 16'h0007);
      set_idling(0, 0);
      queue_random(260);
      wait_drained();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
design/asgr_pkg.sv
design/asgr_parser.sv
design/asgr_result_fifo.sv
design/ansi_sgr_escape_filter.sv
tb/sv/tb_ansi_sgr_escape_filter.sv
